// File: sv/usr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package usr_pkg;

  localparam int REG_WORDS = 1024;
  localparam int AW        = $clog2(REG_WORDS);
  localparam int RX_SHIFT  = 24;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;

  localparam logic [10:0] W_SHIFT_STAT = 11'h004;
  localparam logic [10:0] W_SHIFT_ERR  = 11'h005;
  localparam logic [10:0] W_TIMER_STAT = 11'h006;
  localparam logic [10:0] W_SHIFT_IEN  = 11'h008;
  localparam logic [10:0] W_ERR_IEN    = 11'h009;
  localparam logic [10:0] W_TIMER_IEN  = 11'h00a;
  localparam logic [10:0] W_TX_BUF     = 11'h080;
  localparam logic [10:0] W_RX_BUF     = 11'h081;

  typedef enum logic [2:0] {
    CSR_NONE,
    CSR_SSTAT,
    CSR_SERR,
    CSR_TSTAT,
    CSR_SIEN,
    CSR_EIEN,
    CSR_TIEN
  } csr_sel_t;

  typedef struct packed {
    logic        wr;
    logic        tx_wr;
    logic        rx_set;
    logic        rx_clr;
    csr_sel_t    sel;
    logic [31:0] wdata;
  } csr_cmd_t;

  function automatic csr_sel_t csr_decode(input logic [10:0] idx);
    csr_sel_t sel;
    unique case (idx)
      W_SHIFT_STAT: sel = CSR_SSTAT;
      W_SHIFT_ERR:  sel = CSR_SERR;
      W_TIMER_STAT: sel = CSR_TSTAT;
      W_SHIFT_IEN:  sel = CSR_SIEN;
      W_ERR_IEN:    sel = CSR_EIEN;
      W_TIMER_IEN:  sel = CSR_TIEN;
      default:      sel = CSR_NONE;
    endcase
    return sel;
  endfunction

endpackage
`default_nettype wire

// File: sv/uart_shifter_status_regs.sv
// Serial shifter status register block.
// Input channel (in_valid/in_ready): op, word_index, write_data, rx_byte.
// Result channel (out_valid/out_ready): read_data, irq_level, tx_valid,
// tx_byte; exactly one result per accepted item, in order.
// Config channel (cfg_valid/cfg_ready): link_enabled, always ready; write it
// only while no item is in flight.
// Path: an accepted item passes the read stage, then the output register.
// Throughput: one item per cycle if output not stalled; plain words sit in a
// single-port-write, registered-read RAM, status/enable words in flip-flops.
// Reset: rst_n low clears status/enable words (shifter status bit 0 set) and
// starts a clearing pass that zeroes all REG_WORDS (1024) RAM words, during
// which in_ready stays low.
// Stall: with out_valid held and out_ready low, one more item can be taken
// into the read stage, then in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module uart_shifter_status_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [10:0] in_word_index,
  input  wire logic [31:0] in_write_data,
  input  wire logic [7:0]  in_rx_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] out_read_data,
  output      logic        out_irq_level,
  output      logic        out_tx_valid,
  output      logic [7:0]  out_tx_byte,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic        cfg_link_enabled
);

  localparam int AW = usr_pkg::AW;

  typedef enum logic [1:0] {SRC_ZERO, SRC_RAM, SRC_CSR} src_t;

  logic          link_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  logic          s1_v_r;
  src_t          s1_src_r;
  logic [31:0]   s1_csr_r;
  logic          s1_tx_v_r;
  logic [7:0]    s1_tx_byte_r;

  logic          out_valid_r;
  logic [31:0]   out_read_data_r;
  logic          out_irq_r;
  logic          out_tx_valid_r;
  logic [7:0]    out_tx_byte_r;

  logic              acc, s1_go, in_win, is_rd, is_wr, is_rx, tx_v;
  usr_pkg::csr_sel_t sel;
  usr_pkg::csr_cmd_t cmd;
  logic [31:0]       csr_rd, ram_rdata, ram_wdata;
  logic              csr_irq, ram_we;
  logic [AW-1:0]     ram_waddr;

  assign cfg_ready = 1'b1;
  assign s1_go     = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready  = !clr_busy_r && (!s1_v_r || s1_go);
  assign acc       = in_valid && in_ready;

  assign in_win = 32'(in_word_index) < 32'(usr_pkg::REG_WORDS);
  assign sel    = usr_pkg::csr_decode(in_word_index);
  assign is_rd  = acc && in_op == usr_pkg::OP_READ && in_win;
  assign is_wr  = acc && in_op == usr_pkg::OP_WRITE && in_win;
  assign is_rx  = acc && in_op == usr_pkg::OP_RX;
  assign tx_v   = is_wr && in_word_index == usr_pkg::W_TX_BUF
                  && in_write_data != 32'hffff_ffff && link_r;

  always_comb begin
    cmd.wr     = is_wr && sel != usr_pkg::CSR_NONE;
    cmd.tx_wr  = is_wr && in_word_index == usr_pkg::W_TX_BUF;
    cmd.rx_set = is_rx;
    cmd.rx_clr = is_rd && in_word_index == usr_pkg::W_RX_BUF;
    cmd.sel    = sel;
    cmd.wdata  = in_write_data;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(in_word_index);
    ram_wdata = in_write_data;
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (is_rx) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(usr_pkg::W_RX_BUF);
      ram_wdata = 32'(in_rx_byte) << usr_pkg::RX_SHIFT;
    end else if (is_wr && sel == usr_pkg::CSR_NONE) begin
      ram_we = 1'b1;
    end
  end

  usr_csr u_csr (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_data (csr_rd),
    .irq     (csr_irq)
  );

  usr_ram #(
    .DEPTH (usr_pkg::REG_WORDS),
    .WIDTH (32)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (is_rd),
    .raddr (AW'(in_word_index)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r      <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) link_r <= cfg_link_enabled;
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(usr_pkg::REG_WORDS - 1)) clr_busy_r <= 1'b0;
      end
      if (acc) s1_v_r <= 1'b1;
      else if (s1_go) s1_v_r <= 1'b0;
      if (s1_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (!is_rd) s1_src_r <= SRC_ZERO;
      else if (sel != usr_pkg::CSR_NONE) s1_src_r <= SRC_CSR;
      else s1_src_r <= SRC_RAM;
      s1_csr_r     <= csr_rd;
      s1_tx_v_r    <= tx_v;
      s1_tx_byte_r <= tx_v ? in_write_data[7:0] : 8'h00;
    end
    if (s1_go) begin
      case (s1_src_r)
        SRC_RAM: out_read_data_r <= ram_rdata;
        SRC_CSR: out_read_data_r <= s1_csr_r;
        default: out_read_data_r <= '0;
      endcase
      out_irq_r      <= csr_irq;
      out_tx_valid_r <= s1_tx_v_r;
      out_tx_byte_r  <= s1_tx_byte_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_irq_level = out_irq_r;
  assign out_tx_valid  = out_tx_valid_r;
  assign out_tx_byte   = out_tx_byte_r;

  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_tx_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == usr_pkg::OP_WRITE && in_word_index == usr_pkg::W_TX_BUF
     && in_write_data != 32'hffff_ffff && link_r) |=> (s1_v_r && s1_tx_v_r))
    else $error("transmit write did not emit a byte");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("result lost between read stage and output");

  a_no_tx_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == usr_pkg::OP_READ) |=> !s1_tx_v_r)
    else $error("read emitted a transmit byte");

endmodule
`default_nettype wire

// File: sv/usr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module usr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/usr_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module usr_csr (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire usr_pkg::csr_cmd_t cmd,
  output      logic [31:0]      rd_data,
  output      logic             irq
);

  logic [31:0] sstat_r, serr_r, tstat_r, sien_r, eien_r, tien_r;
  logic [31:0] sstat_nxt, serr_nxt, tstat_nxt, sien_nxt, eien_nxt, tien_nxt;

  always_comb begin
    sstat_nxt = sstat_r;
    serr_nxt  = serr_r;
    tstat_nxt = tstat_r;
    sien_nxt  = sien_r;
    eien_nxt  = eien_r;
    tien_nxt  = tien_r;
    if (cmd.wr) begin
      unique case (cmd.sel)
        usr_pkg::CSR_SSTAT: sstat_nxt = sstat_r & ~cmd.wdata;
        usr_pkg::CSR_SERR:  serr_nxt  = serr_r & ~cmd.wdata;
        usr_pkg::CSR_TSTAT: tstat_nxt = (tstat_r & ~cmd.wdata) | (cmd.wdata & tien_r);
        usr_pkg::CSR_SIEN: begin
          sien_nxt = cmd.wdata;
          if (cmd.wdata[0]) sstat_nxt[0] = 1'b1;
        end
        usr_pkg::CSR_EIEN:  eien_nxt = cmd.wdata;
        usr_pkg::CSR_TIEN: begin
          tien_nxt = cmd.wdata;
          if (cmd.wdata[0]) tstat_nxt[0] = 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd.tx_wr)  sstat_nxt[0] = 1'b1;
    if (cmd.rx_set) sstat_nxt[1] = 1'b1;
    if (cmd.rx_clr) sstat_nxt[1] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sstat_r <= 32'h1;
      serr_r  <= '0;
      tstat_r <= '0;
      sien_r  <= '0;
      eien_r  <= '0;
      tien_r  <= '0;
    end else begin
      sstat_r <= sstat_nxt;
      serr_r  <= serr_nxt;
      tstat_r <= tstat_nxt;
      sien_r  <= sien_nxt;
      eien_r  <= eien_nxt;
      tien_r  <= tien_nxt;
    end
  end

  always_comb begin
    unique case (cmd.sel)
      usr_pkg::CSR_SSTAT: rd_data = sstat_r;
      usr_pkg::CSR_SERR:  rd_data = serr_r;
      usr_pkg::CSR_TSTAT: rd_data = tstat_r;
      usr_pkg::CSR_SIEN:  rd_data = sien_r;
      usr_pkg::CSR_EIEN:  rd_data = eien_r;
      usr_pkg::CSR_TIEN:  rd_data = tien_r;
      default:            rd_data = '0;
    endcase
  end

  assign irq = |((sstat_r & sien_r) | (serr_r & eien_r) | (tstat_r & tien_r));

endmodule
`default_nettype wire

// File: verif/uart_shifter_status_regs_test.sv
`timescale 1ns / 1ps
module uart_shifter_status_regs_test;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AFTER = 300;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] idx;
    logic [31:0] wdata;
    logic [7:0]  rx;
  } access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic        txv;
    logic [7:0]  txb;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [10:0] in_word_index = '0;
  logic [31:0] in_write_data = '0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;
  logic        out_irq_level;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_link_enabled = 1'b0;

  uart_shifter_status_regs dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_word_index    (in_word_index),
    .in_write_data    (in_write_data),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_irq_level    (out_irq_level),
    .out_tx_valid     (out_tx_valid),
    .out_tx_byte      (out_tx_byte),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_link_enabled (cfg_link_enabled)
  );

  always #1 clk = ~clk;

  // register file image and link setting as the block should hold them
  logic [31:0] regs [usr_pkg::REG_WORDS];
  logic        link_on;

  access_t access_queue[$];
  resp_t   expected_resp[$];

  int err_count = 0;
  int results_seen = 0;
  int n_read = 0, n_write = 0, n_rx = 0, n_unused = 0, n_outside = 0;
  int n_tx = 0, n_irq = 0, n_link = 0;

  function automatic void regs_reset();
    for (int i = 0; i < usr_pkg::REG_WORDS; i++) regs[i] = '0;
    regs[usr_pkg::W_SHIFT_STAT] = 32'h1;
    link_on = 1'b0;
  endfunction

  function automatic resp_t apply_access(access_t a);
    resp_t r;
    logic [31:0] w;
    r = '0;
    w = a.wdata;
    case (a.op)
      usr_pkg::OP_READ: begin
        if (a.idx < usr_pkg::REG_WORDS) begin
          r.rdata = regs[a.idx];
          if (a.idx == usr_pkg::W_RX_BUF) regs[usr_pkg::W_SHIFT_STAT][1] = 1'b0;
        end
      end
      usr_pkg::OP_WRITE: begin
        if (a.idx < usr_pkg::REG_WORDS) begin
          case (a.idx)
            usr_pkg::W_SHIFT_STAT, usr_pkg::W_SHIFT_ERR: regs[a.idx] = regs[a.idx] & ~w;
            usr_pkg::W_TIMER_STAT: begin
              regs[usr_pkg::W_TIMER_STAT] = (regs[usr_pkg::W_TIMER_STAT] & ~w)
                                            | (w & regs[usr_pkg::W_TIMER_IEN]);
            end
            usr_pkg::W_SHIFT_IEN: begin
              regs[a.idx] = w;
              if (w[0]) regs[usr_pkg::W_SHIFT_STAT][0] = 1'b1;
            end
            usr_pkg::W_TIMER_IEN: begin
              regs[a.idx] = w;
              if (w[0]) regs[usr_pkg::W_TIMER_STAT][0] = 1'b1;
            end
            usr_pkg::W_TX_BUF: begin
              regs[a.idx] = w;
              if (w != 32'hFFFF_FFFF && link_on) begin
                r.txv = 1'b1;
                r.txb = w[7:0];
              end
              regs[usr_pkg::W_SHIFT_STAT][0] = 1'b1;
            end
            default: regs[a.idx] = w;
          endcase
        end
      end
      usr_pkg::OP_RX: begin
        regs[usr_pkg::W_RX_BUF] = 32'(a.rx) << usr_pkg::RX_SHIFT;
        regs[usr_pkg::W_SHIFT_STAT][1] = 1'b1;
      end
      default: ;
    endcase
    r.irq = |(regs[usr_pkg::W_SHIFT_STAT] & regs[usr_pkg::W_SHIFT_IEN]) |
            |(regs[usr_pkg::W_SHIFT_ERR] & regs[usr_pkg::W_ERR_IEN]) |
            |(regs[usr_pkg::W_TIMER_STAT] & regs[usr_pkg::W_TIMER_IEN]);
    return r;
  endfunction

  function automatic access_t rand_access();
    access_t a;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) a.op = usr_pkg::OP_READ;
    else if (sel < 80) a.op = usr_pkg::OP_WRITE;
    else if (sel < 96) a.op = usr_pkg::OP_RX;
    else a.op = OP_NONE;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      case ($urandom_range(0, 7))
        0: a.idx = usr_pkg::W_SHIFT_STAT;
        1: a.idx = usr_pkg::W_SHIFT_ERR;
        2: a.idx = usr_pkg::W_TIMER_STAT;
        3: a.idx = usr_pkg::W_SHIFT_IEN;
        4: a.idx = usr_pkg::W_ERR_IEN;
        5: a.idx = usr_pkg::W_TIMER_IEN;
        6: a.idx = usr_pkg::W_TX_BUF;
        default: a.idx = usr_pkg::W_RX_BUF;
      endcase
    end else if (sel < 70) begin
      a.idx = 11'($urandom_range(0, 15));
    end else if (sel < 80) begin
      a.idx = 11'($urandom_range(usr_pkg::REG_WORDS - 4, usr_pkg::REG_WORDS + 3));
    end else begin
      a.idx = 11'($urandom_range(0, 2047));
    end
    case ($urandom_range(0, 9))
      0: a.wdata = 32'hFFFF_FFFF;
      1: a.wdata = '0;
      2: a.wdata = $urandom_range(0, 7);
      default: a.wdata = $urandom;
    endcase
    a.rx = 8'($urandom_range(0, 255));
    return a;
  endfunction

  task automatic queue_access(logic [1:0] op, logic [10:0] idx, logic [31:0] wd,
                              logic [7:0] rx);
    access_queue.push_back('{op: op, idx: idx, wdata: wd, rx: rx});
  endtask

  // sender: bursts of items separated by random gaps
  logic offering = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      offering = 1'b0;
      burst_left = 0;
      gap_left = 0;
      in_valid <= 1'b0;
    end else begin
      if (offering && in_ready) begin
        expected_resp.push_back(apply_access('{op: in_op, idx: in_word_index,
                                               wdata: in_write_data, rx: in_rx_byte}));
        case (in_op)
          usr_pkg::OP_READ:  n_read++;
          usr_pkg::OP_WRITE: n_write++;
          usr_pkg::OP_RX:    n_rx++;
          default:           n_unused++;
        endcase
        if (in_op inside {usr_pkg::OP_READ, usr_pkg::OP_WRITE}
            && in_word_index >= usr_pkg::REG_WORDS) n_outside++;
        offering = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_queue.size() > 0) begin
          access_t a;
          a = access_queue.pop_front();
          in_op <= a.op;
          in_word_index <= a.idx;
          in_write_data <= a.wdata;
          in_rx_byte <= a.rx;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off
  int       rcv_cycle = 0;
  int       rcv_mode = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rcv_cycle++;
      if (rcv_cycle % 97 == 0) rcv_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        case (rcv_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rcv_cycle % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // result checker
  resp_t got_resp, want_resp;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      got_resp = '{rdata: out_read_data, irq: out_irq_level, txv: out_tx_valid,
                   txb: out_tx_byte};
      if (got_resp.txv) n_tx++;
      if (got_resp.irq) n_irq++;
      if (expected_resp.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected result rdata=%h irq=%b txv=%b txb=%h", $realtime,
                   got_resp.rdata, got_resp.irq, got_resp.txv, got_resp.txb);
      end else begin
        want_resp = expected_resp.pop_front();
        if (got_resp !== want_resp) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: result %0d exp rdata=%h irq=%b txv=%b txb=%h",
                     $realtime, results_seen, want_resp.rdata, want_resp.irq,
                     want_resp.txv, want_resp.txb);
            $display("%0t: result %0d got rdata=%h irq=%b txv=%b txb=%h",
                     $realtime, results_seen, got_resp.rdata, got_resp.irq,
                     got_resp.txv, got_resp.txb);
          end
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain();
    while (access_queue.size() != 0 || offering || expected_resp.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_link(logic v);
    cfg_valid <= 1'b1;
    cfg_link_enabled <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    link_on = v;
    n_link++;
  endtask

  initial begin
    regs_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_link(1'b0);
    queue_access(usr_pkg::OP_READ,  usr_pkg::W_SHIFT_STAT, 32'h0, 8'h00);
    queue_access(usr_pkg::OP_READ,  11'd0, 32'h0, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_TX_BUF, 32'h0000_00A5, 8'h00);
    queue_access(usr_pkg::OP_WRITE, 11'(usr_pkg::REG_WORDS - 1), 32'hFFFF_FFFF, 8'h00);
    queue_access(usr_pkg::OP_READ,  11'(usr_pkg::REG_WORDS - 1), 32'h0, 8'h00);
    queue_access(usr_pkg::OP_WRITE, 11'(usr_pkg::REG_WORDS), 32'h1234_5678, 8'hFF);
    queue_access(usr_pkg::OP_READ,  11'(usr_pkg::REG_WORDS), 32'hFFFF_FFFF, 8'hFF);
    queue_access(usr_pkg::OP_WRITE, 11'h7FF, 32'hFFFF_FFFF, 8'hFF);
    queue_access(usr_pkg::OP_READ,  11'h7FF, 32'h0, 8'h00);
    queue_access(OP_NONE,           usr_pkg::W_SHIFT_STAT, 32'hFFFF_FFFF, 8'hFF);
    queue_access(usr_pkg::OP_RX,    11'h7FF, 32'hFFFF_FFFF, 8'hFF);
    queue_access(usr_pkg::OP_READ,  usr_pkg::W_RX_BUF, 32'h0, 8'h00);
    queue_access(usr_pkg::OP_READ,  usr_pkg::W_SHIFT_STAT, 32'h0, 8'h00);
    queue_access(usr_pkg::OP_RX,    11'd0, 32'h0, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_SHIFT_IEN, 32'h0000_0003, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_SHIFT_STAT, 32'hFFFF_FFFF, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_ERR_IEN, 32'hFFFF_FFFF, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_SHIFT_ERR, 32'hFFFF_FFFF, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_TIMER_IEN, 32'h0000_0005, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_TIMER_STAT, 32'h0000_0006, 8'h00);
    queue_access(usr_pkg::OP_READ,  usr_pkg::W_TIMER_STAT, 32'h0, 8'h00);
    drain();

    set_link(1'b1);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_TX_BUF, 32'hFFFF_FFFF, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_TX_BUF, 32'h1234_5678, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_TX_BUF, 32'hFFFF_FF00, 8'h00);
    queue_access(usr_pkg::OP_WRITE, usr_pkg::W_TX_BUF, 32'h7FFF_FFFF, 8'h00);
    queue_access(usr_pkg::OP_READ,  usr_pkg::W_TX_BUF, 32'h0, 8'h00);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_link(ph == 3 ? 1'($urandom_range(0, 1)) : 1'(ph % 2 == 0));
      for (int i = 0; i < 250; i++) access_queue.push_back(rand_access());
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d reads, %0d writes, %0d rx bytes, %0d unused ops, %0d outside",
             n_read, n_write, n_rx, n_unused, n_outside);
    $display("%0d tx bytes, %0d irq results, %0d link settings, long stall %s",
             n_tx, n_irq, n_link, hold_done ? "done" : "missed");
    if (err_count == 0 && expected_resp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results outstanding", err_count, expected_resp.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
